@@ hdl/base64url_stream_encoder_unit_macros.svh @@
// Assertion macros shared by the checker module of the encoder.
`ifndef BASE64URL_STREAM_ENCODER_UNIT_MACROS_SVH
`define BASE64URL_STREAM_ENCODER_UNIT_MACROS_SVH

// Same-cycle implication, sampled on aclk and disabled while aresetn is low.
`define B64U_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |-> cons) else $error(msg);

// Next-cycle implication, sampled on aclk and disabled while aresetn is low.
`define B64U_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |=> cons) else $error(msg);

`endif

@@ hdl/b64u_pkg.sv @@
// Package with the word types, queue entry type and symbol helpers of the encoder.
package b64u_pkg;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       final_byte;
    } in_word_t;

    typedef struct packed {
        logic [7:0] out_char;
        logic       last_char;
    } out_word_t;

    typedef logic [5:0] sym_t;

    // One classified input byte: one or two symbols, the mark goes on the second.
    typedef struct packed {
        sym_t sym0;
        sym_t sym1;
        logic two;
        logic fin;
    } q_entry_t;

    localparam logic [1:0] PHASE_0 = 2'd0;
    localparam logic [1:0] PHASE_1 = 2'd1;
    localparam logic [1:0] PHASE_2 = 2'd2;

    localparam int QUEUE_DEPTH = 4;

    function automatic logic [7:0] sym_to_ascii(input sym_t sym);
        logic [7:0] code;
        code = {2'b00, sym};
        if (sym < 6'd26) begin
            return 8'h41 + code;
        end else if (sym < 6'd52) begin
            return 8'h61 + code - 8'd26;
        end else if (sym < 6'd62) begin
            return 8'h30 + code - 8'd52;
        end else if (sym == 6'd62) begin
            return 8'h2D;
        end else begin
            return 8'h5F;
        end
    endfunction

endpackage

@@ hdl/b64u_front.sv @@
// Front end: accepts bytes, tracks the group phase and splits each byte into symbols.
module b64u_front
    import b64u_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  in_word_t s_word,
    input  logic     q_full,
    output logic     q_push,
    output q_entry_t q_entry
);

    logic [1:0] phase_reg, phase_next;
    logic [3:0] left_reg, left_next;
    logic [7:0] b;
    logic       fin;

    assign s_ready = !q_full;
    assign q_push  = s_valid && !q_full;
    assign b       = s_word.data_byte;
    assign fin     = s_word.final_byte;

    always_comb begin
        q_entry    = '0;
        phase_next = PHASE_0;
        left_next  = '0;
        case (phase_reg)
            PHASE_1: begin
                q_entry.sym0 = {left_reg[1:0], b[7:4]};
                if (fin) begin
                    q_entry.sym1 = {b[3:0], 2'b00};
                    q_entry.two  = 1'b1;
                    q_entry.fin  = 1'b1;
                end else begin
                    left_next  = b[3:0];
                    phase_next = PHASE_2;
                end
            end
            PHASE_2: begin
                q_entry.sym0 = {left_reg, b[7:6]};
                q_entry.sym1 = b[5:0];
                q_entry.two  = 1'b1;
                q_entry.fin  = fin;
            end
            default: begin
                // The unused phase code behaves as the start of a group.
                q_entry.sym0 = b[7:2];
                if (fin) begin
                    q_entry.sym1 = {b[1:0], 4'b0000};
                    q_entry.two  = 1'b1;
                    q_entry.fin  = 1'b1;
                end else begin
                    left_next  = {2'b00, b[1:0]};
                    phase_next = PHASE_1;
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PHASE_0;
            left_reg  <= '0;
        end else if (q_push) begin
            phase_reg <= phase_next;
            left_reg  <= left_next;
        end
    end

endmodule

@@ hdl/b64u_queue.sv @@
// Short queue of classified bytes between the front end and the back end.
module b64u_queue
    import b64u_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     push,
    input  q_entry_t push_entry,
    input  logic     pop,
    output q_entry_t pop_entry,
    output logic     full,
    output logic     empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    q_entry_t         entries_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign full      = count_reg == CNT_W'(DEPTH);
    assign empty     = count_reg == '0;
    assign do_push   = push && !full;
    assign do_pop    = pop && !empty;
    assign pop_entry = entries_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entries_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

@@ hdl/b64u_back.sv @@
// Back end: turns queued symbols into ASCII characters, one per cycle while m_ready allows, into the output register.
module b64u_back
    import b64u_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      q_empty,
    output logic      q_pop,
    input  q_entry_t  q_entry,
    output logic      m_valid,
    input  logic      m_ready,
    output out_word_t m_word
);

    logic      m_valid_reg, m_valid_next;
    out_word_t m_word_reg, m_word_next;
    logic      pend_reg, pend_next;
    sym_t      pend_sym_reg, pend_sym_next;
    logic      pend_last_reg, pend_last_next;
    logic      load;

    assign m_valid = m_valid_reg;
    assign m_word  = m_word_reg;
    assign load    = !m_valid_reg || m_ready;

    always_comb begin
        m_valid_next   = m_valid_reg;
        m_word_next    = m_word_reg;
        pend_next      = pend_reg;
        pend_sym_next  = pend_sym_reg;
        pend_last_next = pend_last_reg;
        q_pop          = 1'b0;
        if (load) begin
            if (pend_reg) begin
                // The second symbol of the current entry goes out before the next pop.
                m_valid_next          = 1'b1;
                m_word_next.out_char  = sym_to_ascii(pend_sym_reg);
                m_word_next.last_char = pend_last_reg;
                pend_next             = 1'b0;
            end else if (!q_empty) begin
                q_pop                 = 1'b1;
                m_valid_next          = 1'b1;
                m_word_next.out_char  = sym_to_ascii(q_entry.sym0);
                m_word_next.last_char = 1'b0;
                pend_next             = q_entry.two;
                pend_sym_next         = q_entry.sym1;
                pend_last_next        = q_entry.fin;
            end else begin
                m_valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
            pend_reg    <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
            pend_reg    <= pend_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_word_reg    <= m_word_next;
        pend_sym_reg  <= pend_sym_next;
        pend_last_reg <= pend_last_next;
    end

endmodule

@@ hdl/base64url_stream_encoder_unit.sv @@
// Top level of the unpadded base64url stream encoder.
//
//  Channel  | Ports                       | Word
//  ---------+-----------------------------+-------------------------------
//  input    | s_valid, s_ready, s_word    | data_byte, final_byte
//  result   | m_valid, m_ready, m_word    | out_char, last_char
//
// Each input byte gives one or two characters; the back end sends one character
// per cycle from its output register while m_ready allows, so a byte that gives two
// characters holds it for both, and the other bytes sustain one byte per cycle.
// When the block is empty, an accepted byte passes the queue and then the output register.
// The queue holds QUEUE_DEPTH_P words; s_ready drops only when it is full.
// aresetn is synchronous and active low; it clears the phase, the queue and the output valid.
module base64url_stream_encoder_unit
    import b64u_pkg::*;
#(
    parameter int QUEUE_DEPTH_P = QUEUE_DEPTH
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_word_t  s_word,
    output logic      m_valid,
    input  logic      m_ready,
    output out_word_t m_word
);

    logic     q_push, q_pop, q_full, q_empty;
    q_entry_t push_entry, pop_entry;

    b64u_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_word  (s_word),
        .q_full  (q_full),
        .q_push  (q_push),
        .q_entry (push_entry)
    );

    b64u_queue #(
        .DEPTH (QUEUE_DEPTH_P)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_entry (push_entry),
        .pop        (q_pop),
        .pop_entry  (pop_entry),
        .full       (q_full),
        .empty      (q_empty)
    );

    b64u_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_empty (q_empty),
        .q_pop   (q_pop),
        .q_entry (pop_entry),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_word  (m_word)
    );

endmodule

@@ hdl/b64u_checker.sv @@
// Port-level checker for the encoder, bound to the top level.
`include "base64url_stream_encoder_unit_macros.svh"

module b64u_checker
    import b64u_pkg::*;
(
    input logic      aclk,
    input logic      aresetn,
    input logic      s_valid,
    input logic      s_ready,
    input in_word_t  s_word,
    input logic      m_valid,
    input logic      m_ready,
    input out_word_t m_word
);

    logic acc_in;
    logic alpha_ok;

    assign acc_in   = s_valid && s_ready;
    assign alpha_ok = (m_word.out_char >= 8'h41 && m_word.out_char <= 8'h5A) ||
                      (m_word.out_char >= 8'h61 && m_word.out_char <= 8'h7A) ||
                      (m_word.out_char >= 8'h30 && m_word.out_char <= 8'h39) ||
                      (m_word.out_char == 8'h2D) || (m_word.out_char == 8'h5F);

    `B64U_ASSERT_NEXT(a_out_hold, m_valid && !m_ready, (m_valid && $stable(m_word)), "result word changed while stalled")
    `B64U_ASSERT_IMPL(a_alphabet, m_valid, alpha_ok, "character outside the base64url alphabet")
    `B64U_ASSERT_IMPL(a_reaches_out, acc_in && !m_valid, ##2 m_valid, "accepted byte did not reach the output")
    `B64U_ASSERT_IMPL(a_s_word_known, acc_in, (!$isunknown(s_word)), "accepted input word has unknown bits")

endmodule

bind base64url_stream_encoder_unit b64u_checker u_checker (.*);
